// File: src/lir_pkg.sv
// Shared constants for the linear interpolation resampler.
package lir_pkg;

  localparam int SAMPLE_WIDTH = 16;
  localparam int FRAC_BITS    = 16;
  localparam int MAX_UPSAMPLE = 32;
  localparam int STEP_W       = 24;

endpackage

// File: src/lir_lerp.sv
// Shared interpolation unit: registered multiply, then round and saturate.
module lir_lerp #(
  parameter int SW = lir_pkg::SAMPLE_WIDTH,
  parameter int F  = lir_pkg::FRAC_BITS
) (
  input  logic                 clk,
  input  logic                 load,
  input  logic signed [SW-1:0] a,
  input  logic signed [SW-1:0] b,
  input  logic        [F-1:0]  frac,
  output logic signed [SW-1:0] result
);

  localparam int ACC_W = F + SW + 2;
  localparam logic signed [ACC_W-1:0] HALF = ACC_W'(64'd1 << (F - 1));
  localparam logic signed [SW+1:0] R_MAX = {3'b000, {(SW-1){1'b1}}};
  localparam logic signed [SW+1:0] R_MIN = {3'b111, {(SW-1){1'b0}}};

  logic signed [SW-1:0]    a_r;
  logic signed [ACC_W-1:0] prod_r;
  logic signed [F:0]       fs;
  logic signed [SW:0]      diff;
  logic signed [ACC_W-1:0] acc;
  logic signed [SW+1:0]    rnd;

  assign fs   = signed'({1'b0, frac});
  assign diff = SW'(b) - SW'(a);

  always_ff @(posedge clk) begin
    if (load) begin
      a_r    <= a;
      prod_r <= ACC_W'(fs * diff);
    end
  end

  always_comb begin
    acc = (ACC_W'(a_r) <<< F) + prod_r + HALF;
    rnd = acc[ACC_W-1:F];
    if (rnd > R_MAX) begin
      result = R_MAX[SW-1:0];
    end else if (rnd < R_MIN) begin
      result = R_MIN[SW-1:0];
    end else begin
      result = rnd[SW-1:0];
    end
  end

endmodule

// File: src/lir_seq.sv
// Sequencer: phase accumulator, sample history and output register.
module lir_seq #(
  parameter int SW  = lir_pkg::SAMPLE_WIDTH,
  parameter int F   = lir_pkg::FRAC_BITS,
  parameter int MUP = lir_pkg::MAX_UPSAMPLE
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic        [lir_pkg::STEP_W-1:0] step,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [SW-1:0]              in_sample,
  input  logic                              in_end,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [SW-1:0]              out_sample,
  output logic                              out_last,
  output logic                              out_eos,
  output logic                              lerp_load,
  output logic signed [SW-1:0]              lerp_a,
  output logic signed [SW-1:0]              lerp_b,
  output logic        [F-1:0]               lerp_frac,
  input  logic signed [SW-1:0]              lerp_result
);

  localparam int STEP_W  = lir_pkg::STEP_W;
  localparam int POS_W   = ((STEP_W > F + 1) ? STEP_W : F + 1) + 1;
  localparam int MAX_RES = 2 * MUP;
  localparam int CNT_W   = $clog2(MAX_RES + 1);
  localparam logic [POS_W-1:0]  UNITY    = POS_W'(64'd1 << F);
  localparam logic [POS_W-1:0]  TWO_U    = POS_W'(64'd2 << F);
  localparam logic [STEP_W-1:0] MIN_STEP = STEP_W'((64'd1 << F) / MUP);
  localparam logic [CNT_W-1:0]  CNT_MAX  = CNT_W'(MAX_RES);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_CHECK = 4'b0010,
    S_MUL   = 4'b0100,
    S_HOLD  = 4'b1000
  } state_t;

  state_t               state_r, state_nxt;
  logic [POS_W-1:0]     pos_r, pos_nxt;
  logic signed [SW-1:0] prev_r, prev_nxt;
  logic                 have_r, have_nxt;
  logic                 end_r, end_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic                 out_last_r, out_last_nxt;
  logic                 out_eos_r, out_eos_nxt;
  logic signed [SW-1:0] cur_r;
  logic signed [SW-1:0] out_sample_r;

  logic [STEP_W-1:0]    step_eff;
  logic [POS_W-1:0]     limit;
  logic                 more;
  logic                 accept;
  logic                 on_cur;

  assign step_eff  = (step < MIN_STEP) ? MIN_STEP : step;
  assign limit     = end_r ? TWO_U : UNITY;
  assign more      = (pos_r < limit) && (cnt_r < CNT_MAX);
  assign accept    = in_valid && in_ready;
  assign in_ready  = (state_r == S_IDLE);
  assign on_cur    = (pos_r >= UNITY);
  assign lerp_a    = on_cur ? cur_r : prev_r;
  assign lerp_b    = cur_r;
  assign lerp_frac = on_cur ? '0 : pos_r[F-1:0];

  assign out_valid  = out_valid_r;
  assign out_sample = out_sample_r;
  assign out_last   = out_last_r;
  assign out_eos    = out_eos_r;

  always_comb begin
    state_nxt     = state_r;
    pos_nxt       = pos_r;
    prev_nxt      = prev_r;
    have_nxt      = have_r;
    end_nxt       = end_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r;
    out_last_nxt  = out_last_r;
    out_eos_nxt   = out_eos_r;
    lerp_load     = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          end_nxt   = in_end;
          cnt_nxt   = '0;
          if (!have_r) begin
            prev_nxt = in_sample;
            pos_nxt  = UNITY;
          end
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (more) begin
          lerp_load = 1'b1;
          pos_nxt   = pos_r + POS_W'(step_eff);
          cnt_nxt   = cnt_r + 1'b1;
          state_nxt = S_MUL;
        end else begin
          state_nxt = S_IDLE;
          if (end_r) begin
            prev_nxt = '0;
            pos_nxt  = '0;
            have_nxt = 1'b0;
          end else begin
            prev_nxt = cur_r;
            pos_nxt  = on_cur ? pos_r - UNITY : '0;
            have_nxt = 1'b1;
          end
        end
      end
      S_MUL: begin
        out_valid_nxt = 1'b1;
        out_last_nxt  = !more;
        out_eos_nxt   = !more && end_r;
        state_nxt     = S_HOLD;
      end
      S_HOLD: begin
        if (out_ready) begin
          out_valid_nxt = 1'b0;
          if (out_last_r) begin
            state_nxt = S_IDLE;
            if (end_r) begin
              prev_nxt = '0;
              pos_nxt  = '0;
              have_nxt = 1'b0;
            end else begin
              prev_nxt = cur_r;
              pos_nxt  = on_cur ? pos_r - UNITY : '0;
              have_nxt = 1'b1;
            end
          end else begin
            lerp_load = 1'b1;
            pos_nxt   = pos_r + POS_W'(step_eff);
            cnt_nxt   = cnt_r + 1'b1;
            state_nxt = S_MUL;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pos_r       <= '0;
      prev_r      <= '0;
      have_r      <= 1'b0;
      end_r       <= 1'b0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      out_last_r  <= 1'b0;
      out_eos_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pos_r       <= pos_nxt;
      prev_r      <= prev_nxt;
      have_r      <= have_nxt;
      end_r       <= end_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
      out_last_r  <= out_last_nxt;
      out_eos_r   <= out_eos_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cur_r <= in_sample;
    end
    if (state_r == S_MUL) begin
      out_sample_r <= lerp_result;
    end
  end

  a_valid_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (state_r == S_HOLD))
    else $error("output valid outside hold state");

  a_no_accept_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !out_valid_r)
    else $error("input ready while a result is pending");

  a_eos_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_eos_r) |-> out_last_r)
    else $error("end of stream without last");

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_MAX)
    else $error("result count overflow");

  a_accept_to_check: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == S_CHECK))
    else $error("accepted transaction did not start a check");

endmodule

// File: src/linear_interp_resampler.sv
// Linear interpolation sample rate converter: one input sample per
// transaction on in_*, interpolated samples out on out_*, phase step set
// through cfg_* (Q8.FRAC_BITS input samples per output, reset to unity).
// One shared multiply/round unit computes every output under a small
// sequencer; an item is accepted, then checked, then each of the N outputs
// it causes (0 to 2*MAX_UPSAMPLE) passes through the registered multiply
// and then the output register, and the input is not ready until its last
// output transaction completes.
module linear_interp_resampler #(
  parameter int SAMPLE_WIDTH = lir_pkg::SAMPLE_WIDTH,
  parameter int FRAC_BITS    = lir_pkg::FRAC_BITS,
  parameter int MAX_UPSAMPLE = lir_pkg::MAX_UPSAMPLE,
  parameter int TDATA_W      = ((SAMPLE_WIDTH + 7) / 8) * 8
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [lir_pkg::STEP_W-1:0] cfg_data,   // phase_step
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic [TDATA_W-1:0]         in_tdata,   // sample
  input  logic                       in_tlast,   // end_of_buffer
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [TDATA_W-1:0]         out_tdata,  // out_sample
  output logic                       out_tlast,  // last
  output logic                       out_tuser   // end_of_stream
);

  localparam int STEP_W = lir_pkg::STEP_W;
  localparam logic [STEP_W-1:0] STEP_RESET =
    (FRAC_BITS < STEP_W) ? STEP_W'(64'd1 << FRAC_BITS) : '0;

  logic [STEP_W-1:0]              step_r;
  logic                           lerp_load;
  logic signed [SAMPLE_WIDTH-1:0] lerp_a;
  logic signed [SAMPLE_WIDTH-1:0] lerp_b;
  logic        [FRAC_BITS-1:0]    lerp_frac;
  logic signed [SAMPLE_WIDTH-1:0] lerp_result;
  logic signed [SAMPLE_WIDTH-1:0] out_sample;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= STEP_RESET;
    end else if (cfg_valid) begin
      step_r <= cfg_data;
    end
  end

  lir_seq #(
    .SW  (SAMPLE_WIDTH),
    .F   (FRAC_BITS),
    .MUP (MAX_UPSAMPLE)
  ) u_seq (
    .clk         (clk),
    .rst_n       (rst_n),
    .step        (step_r),
    .in_valid    (in_tvalid),
    .in_ready    (in_tready),
    .in_sample   (signed'(in_tdata[SAMPLE_WIDTH-1:0])),
    .in_end      (in_tlast),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .out_sample  (out_sample),
    .out_last    (out_tlast),
    .out_eos     (out_tuser),
    .lerp_load   (lerp_load),
    .lerp_a      (lerp_a),
    .lerp_b      (lerp_b),
    .lerp_frac   (lerp_frac),
    .lerp_result (lerp_result)
  );

  lir_lerp #(
    .SW (SAMPLE_WIDTH),
    .F  (FRAC_BITS)
  ) u_lerp (
    .clk    (clk),
    .load   (lerp_load),
    .a      (lerp_a),
    .b      (lerp_b),
    .frac   (lerp_frac),
    .result (lerp_result)
  );

  assign out_tdata = TDATA_W'($unsigned(out_sample));

endmodule
